>>> sv/i2a_pkg.sv
// shared types, character constants and helper functions for the integer to text converter
package i2a_pkg;

	// default build values
	localparam int MAX_CHARS_DEF  = 32;
	localparam int VALUE_BITS_DEF = 64;

	// ascii codes
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_A_LC  = 8'h61;
	localparam logic [7:0] ASCII_SPACE = 8'h20;
	localparam logic [7:0] ASCII_MINUS = 8'h2d;
	localparam logic [3:0] DEC_BASE    = 4'd10;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_EMIT
	} i2a_state_t;

	// decimal digits needed for the largest unsigned value of the given width
	function automatic int i2a_dec_digits(input int bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	// one digit in 0..15 to its lower-case ascii code
	function automatic logic [7:0] i2a_digit_char(input logic [3:0] d);
		logic [7:0] d8;
		d8 = {4'b0000, d};
		if (d < DEC_BASE) begin
			return ASCII_ZERO + d8;
		end else begin
			return ASCII_A_LC + d8 - {4'b0000, DEC_BASE};
		end
	endfunction

endpackage

>>> sv/i2a_bcd_unit.sv
// shared double-dabble step: two binary bits shifted into a packed bcd register
module i2a_bcd_unit import i2a_pkg::*; #(
	parameter int NDIG = 20
) (
	input  logic [NDIG*4-1:0] dig_in,
	input  logic [1:0]        bits_in,
	output logic [NDIG*4-1:0] dig_out
);

	localparam int DW = NDIG * 4;

	logic [DW-1:0] adj_a;
	logic [DW-1:0] sft_a;
	logic [DW-1:0] adj_b;

	// first bit: add three to every digit of five or more, then shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj_a[i*4 +: 4] = (dig_in[i*4 +: 4] > 4'd4) ? dig_in[i*4 +: 4] + 4'd3
				: dig_in[i*4 +: 4];
		end
		sft_a = {adj_a[DW-2:0], bits_in[1]};
	end

	// second bit, same step on the result of the first
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj_b[i*4 +: 4] = (sft_a[i*4 +: 4] > 4'd4) ? sft_a[i*4 +: 4] + 4'd3
				: sft_a[i*4 +: 4];
		end
		dig_out = {adj_b[DW-2:0], bits_in[0]};
	end

endmodule

>>> sv/integer_to_ascii_padded_top.sv
// integer to padded ascii text converter: sequencer, digit register and output register
// Converts one integer per transfer into right-aligned ascii text, one character per
// output transfer, most significant first, with last_char on the final one: leading
// spaces up to min(pad_width, MAX_CHARS), a minus sign for a negative signed value,
// then decimal or lower-case hex digits. Steps per item: accept; in decimal mode the
// shared double-dabble unit folds two magnitude bits a cycle into a packed bcd
// register, a step that hex mode skips; then the normalize scan drops leading zero
// digits (up to 19 at 64 bits); then the characters are emitted, one per cycle while
// out_ready is high. in_ready is high only while the sequencer is idle; the last
// character may still wait in the output register when the next item is accepted.
module integer_to_ascii_padded_top import i2a_pkg::*; #(
	parameter int MAX_CHARS  = MAX_CHARS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	input  logic        signed_mode,
	input  logic        radix_hex,
	input  logic [7:0]  pad_width,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  char_code,
	output logic        last_char
);

	localparam int VB2  = VALUE_BITS + (VALUE_BITS % 2);
	localparam int ITER = VB2 / 2;
	localparam int ITW  = $clog2(ITER + 1);
	localparam int NDIG = i2a_dec_digits(VALUE_BITS);
	localparam int DW   = NDIG * 4;
	localparam int NW   = $clog2(NDIG + 1);
	localparam int CW   = $clog2(MAX_CHARS + 1);

	i2a_state_t state_q, state_d;

	logic [VB2-1:0]        mag_q;
	logic [DW-1:0]         dig_q;
	logic [ITW-1:0]        iter_q;
	logic [NW-1:0]         ndig_q;
	logic                  neg_q;
	logic [CW-1:0]         width_q;
	logic [CW-1:0]         pad_q;
	logic                  out_valid_q;
	logic [7:0]            char_code_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] val_in;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;
	logic [DW-1:0]         dig_next;
	logic                  in_fire;
	logic                  emit_fire;
	logic                  top_zero;
	logic                  emit_last;
	logic [CW-1:0]         len;
	logic [7:0]            emit_char;

	// magnitude of the incoming value
	assign val_in   = value[VALUE_BITS-1:0];
	assign neg_in   = signed_mode & val_in[VALUE_BITS-1];
	assign mag_in   = neg_in ? (~val_in + VALUE_BITS'(1)) : val_in;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;

	// shared conversion unit
	i2a_bcd_unit #(
		.NDIG (NDIG)
	) u_bcd (
		.dig_in  (dig_q),
		.bits_in (mag_q[VB2-1 -: 2]),
		.dig_out (dig_next)
	);

	// text length and character selection
	assign top_zero  = (dig_q[DW-1 -: 4] == 4'd0);
	assign len       = CW'(ndig_q) + CW'(neg_q);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit_last = (pad_q == '0) && !neg_q && (ndig_q == NW'(1));

	always_comb begin
		if (pad_q != '0) begin
			emit_char = ASCII_SPACE;
		end else if (neg_q) begin
			emit_char = ASCII_MINUS;
		end else begin
			emit_char = i2a_digit_char(dig_q[DW-1 -: 4]);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = radix_hex ? ST_NORM : ST_CONV;
				end
			end
			ST_CONV: begin
				if (iter_q == ITW'(1)) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (!(top_zero && ndig_q > NW'(1))) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_fire && emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					mag_q   <= VB2'(mag_in);
					dig_q   <= radix_hex ? DW'(mag_in) : '0;
					iter_q  <= ITW'(ITER);
					ndig_q  <= NW'(NDIG);
					neg_q   <= neg_in;
					width_q <= (pad_width > 8'(MAX_CHARS)) ? CW'(MAX_CHARS) : CW'(pad_width);
				end
			end
			ST_CONV: begin
				dig_q  <= dig_next;
				mag_q  <= mag_q << 2;
				iter_q <= iter_q - ITW'(1);
			end
			ST_NORM: begin
				if (top_zero && ndig_q > NW'(1)) begin
					dig_q  <= dig_q << 4;
					ndig_q <= ndig_q - NW'(1);
				end else begin
					pad_q <= (width_q > len) ? width_q - len : '0;
				end
			end
			ST_EMIT: begin
				if (emit_fire) begin
					if (pad_q != '0) begin
						pad_q <= pad_q - CW'(1);
					end else if (neg_q) begin
						neg_q <= 1'b0;
					end else begin
						dig_q  <= dig_q << 4;
						ndig_q <= ndig_q - NW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			char_code_q <= emit_char;
			last_q      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign last_char = last_q;

`ifndef SYNTH
	// an accepted item always starts conversion or normalize
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CONV || state_q == ST_NORM))
		else $error("accepted item did not start conversion");

	// at least one digit remains while normalizing or emitting
	a_ndig: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NORM || state_q == ST_EMIT) |-> (ndig_q != '0))
		else $error("digit count reached zero");

	// padding never exceeds the field limit
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (pad_q <= CW'(MAX_CHARS)))
		else $error("padding count out of range");

	// a last character returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && emit_last) |=> (state_q == ST_IDLE))
		else $error("sequencer stayed busy after last character");
`endif

endmodule
